>>> rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the block buffer cache directory
// Transfer payloads, action and status codes, and the per-slot entry and
// neighbor chain records passed along the row of directory cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int TAG_W     = 32;
  localparam int CNT_W     = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_MARK    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_BUSY   = 3'd2,
    ST_DONE   = 3'd3,
    ST_RELERR = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] device;
    logic [31:0] block_number;
    logic [2:0]  slot_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] slot_out;
    logic       needs_fill;
  } out_item_t;

  // One directory entry; the cell at position 0 is the most recent
  typedef struct packed {
    slot_t             slot;
    logic [TAG_W-1:0]  dev_tag;
    logic [TAG_W-1:0]  blk_tag;
    logic              vld;
    count_t            cnt;
  } entry_t;

  // Chain running from most recent toward least recent
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    logic  hit_fill;
    logic  rel_ok;
  } up_chain_t;

  // Chain running from least recent toward most recent
  typedef struct packed {
    logic   free;
    slot_t  free_slot;
    logic   mtf;
    entry_t mtf_ent;
  } dn_chain_t;

  // Summary of one evaluation of the cell row
  typedef struct packed {
    logic  hit;
    slot_t hit_slot;
    logic  hit_fill;
    logic  rel_ok;
    logic  free;
    slot_t free_slot;
  } chain_sum_t;

endpackage

`default_nettype wire

>>> rtl/lbc_cell.sv
// ----------------------------------------------------------------------------
// lbc_cell: one recency position of the buffer directory
// Holds one slot's tags, valid mark and count; joins the hit, free and
// move-to-front chains and takes its left neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_cell
  import lbc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      exec,
  input  wire in_item_t  req,
  input  wire logic      is_head,
  input  wire slot_t     rst_slot,
  input  wire entry_t    left_ent,
  input  wire logic      hit_any,
  input  wire up_chain_t up_in,
  output up_chain_t      up_out,
  input  wire dn_chain_t dn_in,
  output dn_chain_t      dn_out,
  output entry_t         ent
);

  entry_t ent_r, ent_nxt;
  logic   is_get, is_rel, is_mark;
  logic   match, own_slot, cnt_zero, hit_here, free_here, tgt;
  entry_t tgt_ent;

  // Decode the request against this entry
  always_comb begin
    is_get   = (req.action == ACT_GET);
    is_rel   = (req.action == ACT_RELEASE);
    is_mark  = (req.action == ACT_MARK);
    match    = (ent_r.dev_tag == req.device) && (ent_r.blk_tag == req.block_number);
    own_slot = (ent_r.slot == slot_t'(req.slot_in));
    cnt_zero = (ent_r.cnt == '0);
    hit_here = is_get && match && !up_in.hit;
    free_here = cnt_zero && !dn_in.free;
    tgt      = is_rel && own_slot && (ent_r.cnt == count_t'(1));
    tgt_ent      = ent_r;
    tgt_ent.cnt  = '0;
  end

  // Pass the chains on to the neighbors
  always_comb begin
    up_out.hit      = up_in.hit || (is_get && match);
    up_out.hit_slot = hit_here ? ent_r.slot : up_in.hit_slot;
    up_out.hit_fill = hit_here ? !ent_r.vld : up_in.hit_fill;
    up_out.rel_ok   = up_in.rel_ok || (own_slot && !cnt_zero);
    dn_out.free      = dn_in.free || cnt_zero;
    dn_out.free_slot = free_here ? ent_r.slot : dn_in.free_slot;
    dn_out.mtf       = dn_in.mtf || tgt;
    dn_out.mtf_ent   = tgt ? tgt_ent : dn_in.mtf_ent;
  end

  // Update the entry
  always_comb begin
    ent_nxt = ent_r;
    if (exec) begin
      if (is_rel && dn_out.mtf) begin
        ent_nxt = is_head ? dn_out.mtf_ent : left_ent;
      end else if (is_rel && own_slot && !cnt_zero) begin
        ent_nxt.cnt = ent_r.cnt - count_t'(1);
      end else if (hit_here) begin
        if (ent_r.cnt != COUNT_MAX) begin
          ent_nxt.cnt = ent_r.cnt + count_t'(1);
        end
      end else if (is_get && !hit_any && free_here) begin
        ent_nxt.dev_tag = req.device;
        ent_nxt.blk_tag = req.block_number;
        ent_nxt.vld     = 1'b0;
        ent_nxt.cnt     = count_t'(1);
      end else if (is_mark && own_slot) begin
        ent_nxt.vld = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.slot    <= rst_slot;
      ent_r.dev_tag <= '0;
      ent_r.blk_tag <= '0;
      ent_r.vld     <= 1'b0;
      ent_r.cnt     <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

>>> rtl/lbc_chain.sv
// ----------------------------------------------------------------------------
// lbc_chain: row of directory cells ordered by recency
// Wires the cells to their neighbors and reports the chain ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_chain
  import lbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     exec,
  input  wire in_item_t req,
  output chain_sum_t    sum
);

  entry_t    ent [NUM_SLOTS];
  up_chain_t up  [NUM_SLOTS+1];
  dn_chain_t dn  [NUM_SLOTS+1];

  assign up[0]         = '0;
  assign dn[NUM_SLOTS] = '0;

  // Build the row; position 0 is the most recent
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    lbc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .exec     (exec),
      .req      (req),
      .is_head  (1'(i == 0)),
      .rst_slot (slot_t'(NUM_SLOTS - 1 - i)),
      .left_ent (ent[(i == 0) ? 0 : i - 1]),
      .hit_any  (up[NUM_SLOTS].hit),
      .up_in    (up[i]),
      .up_out   (up[i+1]),
      .dn_in    (dn[i+1]),
      .dn_out   (dn[i]),
      .ent      (ent[i])
    );
  end

  // Collect the chain ends
  always_comb begin
    sum.hit       = up[NUM_SLOTS].hit;
    sum.hit_slot  = up[NUM_SLOTS].hit_slot;
    sum.hit_fill  = up[NUM_SLOTS].hit_fill;
    sum.rel_ok    = up[NUM_SLOTS].rel_ok;
    sum.free      = dn[0].free;
    sum.free_slot = dn[0].free_slot;
  end

endmodule

`default_nettype wire

>>> rtl/lru_block_buffer_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_block_buffer_cache_unit: LRU buffer directory with reference counts
// Request capture, result formatting and the output register.
// ----------------------------------------------------------------------------
// Each request (get, release, mark valid, none) is first captured into the
// request register; then the row of eight recency cells is evaluated and
// updated and the result register loaded. The next request is taken once the
// current one has been evaluated; evaluation waits while a previous result
// is still held by out_stall. Each request gives exactly one result.
// After reset all slots are tagged device 0, block 0, not valid, count 0.
`default_nettype none

module lru_block_buffer_cache_unit
  import lbc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic       busy_r, busy_nxt;
  logic       out_valid_r, out_valid_nxt;
  in_item_t   req_r;
  out_item_t  out_data_r, res;
  logic       in_xfer, exec;
  chain_sum_t sum;

  assign in_stall = busy_r;
  assign in_xfer  = in_valid && !busy_r;
  assign exec     = busy_r && (!out_valid_r || !out_stall);

  lbc_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (exec),
    .req   (req_r),
    .sum   (sum)
  );

  // Format the result
  always_comb begin
    res.status     = ST_DONE;
    res.slot_out   = req_r.slot_in;
    res.needs_fill = 1'b0;
    case (req_r.action)
      ACT_GET: begin
        if (sum.hit) begin
          res.status     = ST_HIT;
          res.slot_out   = 3'(sum.hit_slot);
          res.needs_fill = sum.hit_fill;
        end else if (sum.free) begin
          res.status     = ST_NEW;
          res.slot_out   = 3'(sum.free_slot);
          res.needs_fill = 1'b1;
        end else begin
          res.status = ST_BUSY;
        end
      end
      ACT_RELEASE: begin
        res.status = sum.rel_ok ? ST_DONE : ST_RELERR;
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
  end

  // Advance the control flags
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (exec) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (in_xfer) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payloads
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_data;
    end
    if (exec) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> (out_valid_r && !busy_r))
    else $error("evaluated request did not reach the output register");

  a_new_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_NEW) |-> out_data_r.needs_fill)
    else $error("new allocation without fill request");

  a_fill_only_get: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status == ST_BUSY || out_data_r.status == ST_DONE ||
                     out_data_r.status == ST_RELERR)) |-> !out_data_r.needs_fill)
    else $error("fill request on a non-get result");

  a_no_exec_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !exec)
    else $error("evaluation without a captured request");
`endif

endmodule

`default_nettype wire

>>> bench/tb_lru_block_buffer_cache_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lru_block_buffer_cache_unit: bench for the LRU block buffer directory
// Sends get, release and mark-valid requests and follows them with a
// directory model of the bench's own, which predicts every result. Results
// are checked in order. The run has a short directed opening, then random
// request sequences over a small pool of block tags under four idle and
// stall mixes. A long burst of gets drives one reference count into
// saturation.
// ----------------------------------------------------------------------------

module tb_lru_block_buffer_cache_unit;
  import lbc_pkg::*;

  localparam int POOL_SIZE    = 12;
  localparam int PHASE_ITEMS  = 80;
  localparam int HAMMER_GETS  = 258;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 200;

  // Directory contents: tags, valid marks, counts and recency list
  typedef struct packed {
    logic [NUM_SLOTS-1:0][TAG_W-1:0]  dev_tag;
    logic [NUM_SLOTS-1:0][TAG_W-1:0]  blk_tag;
    logic [NUM_SLOTS-1:0]             vld;
    logic [NUM_SLOTS-1:0][CNT_W-1:0]  cnt;
    logic [NUM_SLOTS-1:0][SLOT_W-1:0] order;
  } dir_state_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  dir_state_t  plan_dir;
  dir_state_t  model_dir;
  in_item_t    pending_q [$];
  out_item_t   expect_q [$];
  out_item_t   model_rsp;
  out_item_t   want;
  logic [31:0] pool_dev [POOL_SIZE];
  logic [31:0] pool_blk [POOL_SIZE];
  int          idle_pcts [4]  = '{0, 47, 0, 18};
  int          stall_pcts [4] = '{0, 0, 47, 18};
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;
  int          mismatches     = 0;
  int          sent_cnt       = 0;
  int          got_cnt        = 0;
  int          status_seen [5];

  lru_block_buffer_cache_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic dir_state_t dir_reset();
    dir_state_t d;
    int i;
    d = '0;
    for (i = 0; i < NUM_SLOTS; i++) d.order[i] = slot_t'(NUM_SLOTS - 1 - i);
    return d;
  endfunction

  // Apply one request to a directory and return the result it gives
  function automatic out_item_t cache_step(inout dir_state_t d, input in_item_t req);
    out_item_t rsp;
    slot_t     s;
    int        i;
    int        pos;
    bit        found;
    rsp.status     = ST_DONE;
    rsp.slot_out   = req.slot_in;
    rsp.needs_fill = 1'b0;
    found          = 1'b0;
    case (action_t'(req.action))
      ACT_GET: begin
        rsp.status = ST_BUSY;
        // search from most recent; a hit keeps the recency order
        for (i = 0; i < NUM_SLOTS; i++) begin
          s = d.order[i];
          if (!found && d.dev_tag[s] == req.device && d.blk_tag[s] == req.block_number) begin
            found = 1'b1;
            if (d.cnt[s] != COUNT_MAX) d.cnt[s] = d.cnt[s] + 1'b1;
            rsp.status     = ST_HIT;
            rsp.slot_out   = s;
            rsp.needs_fill = !d.vld[s];
          end
        end
        // recycle the least recent idle slot
        for (i = NUM_SLOTS - 1; i >= 0; i--) begin
          s = d.order[i];
          if (!found && d.cnt[s] == '0) begin
            found          = 1'b1;
            d.dev_tag[s]   = req.device;
            d.blk_tag[s]   = req.block_number;
            d.vld[s]       = 1'b0;
            d.cnt[s]       = count_t'(1);
            rsp.status     = ST_NEW;
            rsp.slot_out   = s;
            rsp.needs_fill = 1'b1;
          end
        end
      end
      ACT_RELEASE: begin
        if (int'(req.slot_in) >= NUM_SLOTS || d.cnt[req.slot_in] == '0) begin
          rsp.status = ST_RELERR;
        end else begin
          d.cnt[req.slot_in] = d.cnt[req.slot_in] - 1'b1;
          if (d.cnt[req.slot_in] == '0) begin
            pos = 0;
            for (i = NUM_SLOTS - 1; i >= 0; i--) if (d.order[i] == req.slot_in) pos = i;
            for (i = pos; i > 0; i--) d.order[i] = d.order[i-1];
            d.order[0] = req.slot_in;
          end
        end
      end
      ACT_MARK: begin
        if (int'(req.slot_in) < NUM_SLOTS) d.vld[req.slot_in] = 1'b1;
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic in_item_t make_req(action_t act, logic [31:0] dev, logic [31:0] blk,
                                        slot_t s);
    in_item_t req;
    req.action       = act;
    req.device       = dev;
    req.block_number = blk;
    req.slot_in      = s;
    return req;
  endfunction

  // Queue a request and tell the generator what it will answer
  task automatic queue_req(input in_item_t req, output out_item_t rsp);
    rsp = cache_step(plan_dir, req);
    pending_q.push_back(req);
  endtask

  // Drop every reference still held in the planned directory
  task automatic release_all();
    out_item_t r;
    int        s;
    int        k;
    for (s = 0; s < NUM_SLOTS; s++) begin
      for (k = int'(plan_dir.cnt[s]); k > 0; k--) begin
        queue_req(make_req(ACT_RELEASE, $urandom, $urandom, slot_t'(s)), r);
      end
    end
  endtask

  task automatic drain_wait();
    while (pending_q.size() != 0 || in_valid || expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic directed_checks();
    out_item_t r;
    slot_t     first_new;
    int        k;
    // reset tags match device 0 block 0, so the first get hits and needs a fill
    queue_req(make_req(ACT_GET, '0, '0, '0), r);
    queue_req(make_req(ACT_MARK, '1, '1, r.slot_out), r);
    queue_req(make_req(ACT_GET, '0, '0, '1), r);
    queue_req(make_req(ACT_GET, '1, '1, '0), r);
    first_new = r.slot_out;
    queue_req(make_req(ACT_GET, '1, '0, '1), r);
    queue_req(make_req(ACT_GET, '0, '1, '0), r);
    for (k = 0; k < 4; k++) begin
      queue_req(make_req(ACT_GET, 32'hA5A5_A5A5 ^ k, 32'h5A5A_5A5A + k, slot_t'(k)), r);
    end
    // every slot now holds a reference: no free slot
    queue_req(make_req(ACT_GET, 32'h1234_5678, 32'h9ABC_DEF0, slot_t'(5)), r);
    // release down to zero, then once more on a zero count
    queue_req(make_req(ACT_RELEASE, '0, '0, first_new), r);
    queue_req(make_req(ACT_RELEASE, '1, '1, first_new), r);
    queue_req(make_req(ACT_NONE, $urandom, $urandom, slot_t'(6)), r);
    // idle slot keeps its tags and was never marked valid, so the get hits and needs a fill
    queue_req(make_req(ACT_GET, '1, '1, '0), r);
    release_all();
  endtask

  // Mostly well-formed get / fill / release sequences, with some noise
  task automatic random_traffic(input int n);
    out_item_t r;
    int        done;
    int        pick;
    int        s;
    int        k;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        k = $urandom_range(POOL_SIZE - 1);
        queue_req(make_req(ACT_GET, pool_dev[k], pool_blk[k], slot_t'($urandom_range(7))), r);
        done++;
        if (r.needs_fill && $urandom_range(3) != 0) begin
          queue_req(make_req(ACT_MARK, $urandom, $urandom, r.slot_out), r);
          done++;
        end
      end else if (pick < 80) begin
        // pick a held slot when one exists
        s = $urandom_range(NUM_SLOTS - 1);
        for (k = 0; k < NUM_SLOTS && plan_dir.cnt[s] == '0; k++) s = (s + 1) % NUM_SLOTS;
        queue_req(make_req(ACT_RELEASE, $urandom, $urandom, slot_t'(s)), r);
        done++;
      end else if (pick < 88) begin
        queue_req(make_req(ACT_MARK, $urandom, $urandom, slot_t'($urandom_range(7))), r);
        done++;
      end else begin
        queue_req(make_req(action_t'($urandom_range(3)), $urandom, $urandom,
                           slot_t'($urandom_range(7))), r);
        done++;
      end
    end
  endtask

  // Driver: predict on each accepted transfer, then offer the next request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        model_rsp = cache_step(model_dir, in_data);
        expect_q.push_back(model_rsp);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        got_cnt++;
        if (out_data.status <= ST_RELERR) status_seen[out_data.status]++;
        if (expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: unexpected result, expected none, got status %0d slot %0d fill %0b",
                     $time, out_data.status, out_data.slot_out, out_data.needs_fill);
          end
        end else begin
          want = expect_q.pop_front();
          if (out_data.status !== want.status || out_data.slot_out !== want.slot_out ||
              out_data.needs_fill !== want.needs_fill) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: mismatch, expected status %0d slot %0d fill %0b,",
                       $time, want.status, want.slot_out, want.needs_fill,
                       " got status %0d slot %0d fill %0b",
                       out_data.status, out_data.slot_out, out_data.needs_fill);
            end
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    out_item_t r;
    slot_t     hot_slot;
    int        k;
    int        phase;
    plan_dir  = dir_reset();
    model_dir = dir_reset();
    // tag pool: the extremes, then pairs that share a device or differ in one tag
    pool_dev[0] = '0; pool_blk[0] = '0;
    pool_dev[1] = '1; pool_blk[1] = '1;
    pool_dev[2] = '0; pool_blk[2] = '1;
    pool_dev[3] = '1; pool_blk[3] = '0;
    for (k = 4; k < POOL_SIZE; k++) begin
      pool_dev[k] = (k % 2 == 1) ? pool_dev[k-1] : $urandom;
      pool_blk[k] = (k % 4 == 2) ? pool_blk[k-1] : $urandom;
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_checks();
    drain_wait();

    // one phase per idle/stall mix; the sender pauses until all results are back
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_pcts[phase];
      recv_stall_pct = stall_pcts[phase];
      random_traffic(PHASE_ITEMS);
      if (phase == 3) begin
        // hammer one block until its count saturates, then leave it pinned
        release_all();
        queue_req(make_req(ACT_GET, 32'h1357_9BDF, 32'h2468_ACE0, '0), r);
        hot_slot = r.slot_out;
        for (k = 1; k < HAMMER_GETS; k++) begin
          queue_req(make_req(ACT_GET, 32'h1357_9BDF, 32'h2468_ACE0, slot_t'(k)), r);
        end
        queue_req(make_req(ACT_MARK, '0, '0, hot_slot), r);
        for (k = 0; k < 3; k++) queue_req(make_req(ACT_RELEASE, '0, '0, hot_slot), r);
        random_traffic(PHASE_ITEMS / 2);
      end
      drain_wait();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d requests and checked %0d results over four idle/stall mixes.",
             sent_cnt, got_cnt);
    $display("Seen: %0d hits, %0d allocations, %0d all busy, %0d done, %0d release errors.",
             status_seen[ST_HIT], status_seen[ST_NEW], status_seen[ST_BUSY],
             status_seen[ST_DONE], status_seen[ST_RELERR]);
    if (mismatches == 0 && expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expect_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
